### src/lcs_pkg.sv
// Shared types, sizes and the fixed-point log helper for the per-source spread counter.
package lcs_pkg;

    // Sizes of the source table and of each bitmap.
    localparam int BITMAP_BITS = 1024;
    localparam int NUM_SOURCES = 64;
    localparam int WORDS       = (BITMAP_BITS + 63) / 64;
    localparam int WORD_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int POS_W       = $clog2(BITMAP_BITS);
    localparam bit MAP_POW2    = ((1 << POS_W) == BITMAP_BITS);
    localparam int CNT_W       = $clog2(BITMAP_BITS + 1);
    localparam int D_W         = POS_W + 1;
    localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int RAM_DEPTH   = NUM_SOURCES * WORDS;
    localparam int ADDR_W      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int SRC_W       = 32;
    localparam int SPREAD_W    = 16;
    localparam int FRAC_BITS   = 28;
    localparam int LOG_W       = 32;
    localparam int MUL_W       = 64;
    localparam int RND_W       = 32 + D_W;
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    // Input and result words.
    typedef struct packed {
        logic             op;
        logic [SRC_W-1:0] source_id;
        logic [SRC_W-1:0] dest_id;
    } lcs_in_t;

    typedef struct packed {
        logic [SPREAD_W-1:0] spread;
        logic                found;
        logic                table_full;
    } lcs_out_t;

    // Operation codes.
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // What a cell reports and what the controller tells it.
    typedef struct packed {
        logic             hit;
        logic             first_free;
        logic [CNT_W-1:0] count;
    } lcs_cell_stat_t;

    typedef struct packed {
        logic              alloc;
        logic              upd;
        logic [SRC_W-1:0]  source_id;
        logic              inc;
    } lcs_cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SEARCH,
        ST_READ,
        ST_WRITE,
        ST_EST,
        ST_DONE,
        ST_CLEAR
    } lcs_state_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_LOG,
        E_MUL1,
        E_MUL2,
        E_FIN
    } lcs_est_state_t;

    // log2(x) in Q.28 by repeated squaring; used at elaboration only.
    function automatic logic [LOG_W-1:0] log2_fixed(input int unsigned x);
        int unsigned          e;
        logic [63:0]          y;
        logic [FRAC_BITS-1:0] frac;
        e    = 0;
        frac = '0;
        for (int k = 0; k < 31; k++) begin
            if ((x >> e) > 1) begin
                e++;
            end
        end
        y = 64'(x) << (31 - e);
        for (int i = 0; i < FRAC_BITS; i++) begin
            y    = (y * y) >> 31;
            frac = {frac[FRAC_BITS-2:0], 1'b0};
            if (y >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                y       = y >> 1;
            end
        end
        return {e[3:0], frac};
    endfunction

    localparam logic [LOG_W-1:0] LOG_M = log2_fixed(BITMAP_BITS);

endpackage

### src/lcs_ram.sv
// Generic simple dual-port RAM with a registered read.
module lcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/lcs_cell.sv
// One table cell: a source tag and its set-bit count.
module lcs_cell
    import lcs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [SRC_W-1:0] key,
    input  logic             take_in,
    output logic             take_out,
    input  logic             sel,
    input  lcs_cell_cmd_t    cmd,
    output lcs_cell_stat_t   stat
);

    logic             valid_reg, valid_next;
    logic [SRC_W-1:0] source_reg, source_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Allocation starts a clean count; an update adds a newly set bit.
    always_comb begin
        valid_next  = valid_reg;
        source_next = source_reg;
        count_next  = count_reg;
        if (sel && cmd.alloc) begin
            valid_next  = 1'b1;
            source_next = cmd.source_id;
            count_next  = CNT_W'(cmd.inc);
        end else if (sel && cmd.upd) begin
            count_next = count_reg + CNT_W'(cmd.inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        source_reg <= source_next;
        count_reg  <= count_next;
    end

    // The free-slot token passes on only through occupied cells.
    assign take_out        = take_in & valid_reg;
    assign stat.hit        = valid_reg && (source_reg == key);
    assign stat.first_free = take_in & ~valid_reg;
    assign stat.count      = count_reg;

endmodule

### src/lcs_est.sv
// Linear-counting estimate from a set-bit count, one squaring step per cycle.
module lcs_est
    import lcs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [CNT_W-1:0]    count,
    output logic                done,
    output logic [SPREAD_W-1:0] spread
);

    localparam int CHK_SHIFT = FRAC_BITS;

    lcs_est_state_t       state_reg, state_next;
    logic [31:0]          y_reg, y_next;
    logic [3:0]           e_reg, e_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [4:0]           it_reg, it_next;
    logic [MUL_W-1:0]     prod_reg, prod_next;
    logic [RND_W-1:0]     rnd_reg, rnd_next;
    logic [SPREAD_W-1:0]  spread_reg, spread_next;

    logic [CNT_W-1:0] c_clamp;
    logic [D_W-1:0]   d;
    logic [3:0]       e_init;
    logic [63:0]      sq;
    logic [32:0]      sq_shr;
    logic [LOG_W-1:0] diff;
    logic [RND_W-CHK_SHIFT-1:0] rnd_top;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE: if (start) state_next = E_LOG;
            E_LOG:  if (it_reg == 5'(FRAC_BITS - 1)) state_next = E_MUL1;
            E_MUL1: state_next = E_MUL2;
            E_MUL2: state_next = E_FIN;
            E_FIN:  state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    // Datapath: normalize, square, then scale by ln2 and m with rounding and saturation.
    always_comb begin
        c_clamp = (count >= CNT_W'(BITMAP_BITS)) ? CNT_W'(BITMAP_BITS - 1) : count;
        d       = D_W'(BITMAP_BITS) - D_W'(c_clamp);
        e_init  = '0;
        for (int k = 0; k < D_W; k++) begin
            if (d[k]) begin
                e_init = 4'(k);
            end
        end
        sq      = 64'(y_reg) * 64'(y_reg);
        sq_shr  = sq[63:31];
        diff    = LOG_M - {e_reg, frac_reg};
        rnd_top = rnd_reg[RND_W-1:CHK_SHIFT];

        y_next      = y_reg;
        e_next      = e_reg;
        frac_next   = frac_reg;
        it_next     = it_reg;
        prod_next   = prod_reg;
        rnd_next    = rnd_reg;
        spread_next = spread_reg;
        case (state_reg)
            E_IDLE: begin
                if (start) begin
                    e_next    = e_init;
                    y_next    = 32'(d) << (5'd31 - 5'(e_init));
                    frac_next = '0;
                    it_next   = '0;
                end
            end
            E_LOG: begin
                it_next = it_reg + 5'd1;
                if (sq_shr[32]) begin
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b1};
                    y_next    = sq_shr[32:1];
                end else begin
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b0};
                    y_next    = sq_shr[31:0];
                end
            end
            E_MUL1: prod_next = 64'(diff) * 64'(LN2_Q32);
            E_MUL2: begin
                rnd_next = RND_W'(prod_reg[63:32]) * RND_W'(BITMAP_BITS)
                         + RND_W'(1 << (FRAC_BITS - 1));
            end
            E_FIN: begin
                spread_next = (rnd_top > (RND_W - CHK_SHIFT)'(16'hFFFF)) ? 16'hFFFF
                            : SPREAD_W'(rnd_top);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        y_reg      <= y_next;
        e_reg      <= e_next;
        frac_reg   <= frac_next;
        it_reg     <= it_next;
        prod_reg   <= prod_next;
        rnd_reg    <= rnd_next;
        spread_reg <= spread_next;
    end

    assign done   = (state_reg == E_FIN);
    assign spread = spread_next;

endmodule

### src/per_source_linear_counting_spread.sv
// Top level of the per-source spread counter: cell chain, bitmap RAM and control.
//
// Usage: input words (op, source_id, dest_id) arrive on s_valid/s_ready and each
// produces exactly one result word (spread, found, table_full) on m_valid/m_ready.
// One word is worked on at a time; s_ready is high only while the block is idle,
// so the block returns to idle after each word before the next can be taken.
// A record word goes from acceptance to m_valid through a tag compare in the
// cell chain, a priority pick of the first free cell, a read of the bitmap word
// and its write back. With a bitmap size that is not a power of two, a serial
// remainder step comes first. A query that finds its source then runs the log2
// squaring unit, one step per cycle; a query of an unknown source does not.
// The squaring loop and the single bitmap RAM set how long a word takes.
// After reset the block zeroes all 1024 words of the bitmap RAM one word per cycle,
// with s_ready low; cell valid bits clear at once. Entries are never released,
// so a newly allocated entry always finds zeroed bitmap words. The result sits
// in an output register; while the receiver stalls, the next word may already be
// accepted and worked on, and it waits at its end until the register is free.
module per_source_linear_counting_spread
    import lcs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lcs_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lcs_out_t m_data
);

    lcs_state_t       state_reg, state_next;
    lcs_in_t          in_reg;
    logic [POS_W-1:0] rem_reg, rem_next;
    logic [SRC_W-1:0] dsh_reg, dsh_next;
    logic [4:0]       bcnt_reg, bcnt_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [NUM_SOURCES-1:0] hit_vec_reg, free_vec_reg, sel_vec_reg, sel_vec;
    logic [IDX_W-1:0] idx_reg, idx;
    logic             alloc_reg, found_reg, full_reg;
    logic             m_valid_reg;
    lcs_out_t         m_data_reg;
    logic [SPREAD_W-1:0] spread_reg;

    logic [NUM_SOURCES:0]   take;
    lcs_cell_stat_t         stat [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] hit_vec, free_vec, cell_sel;
    lcs_cell_cmd_t          cmd;

    logic [POS_W:0]    rem_t;
    logic              hit_any, free_any, is_rec;
    logic [WORD_W-1:0] word;
    logic [5:0]        bitpos;
    logic [ADDR_W-1:0] addr, waddr;
    logic [63:0]       rdata, old_word, bit_mask, wdata;
    logic [CNT_W-1:0]  sel_count;
    logic              bit_was_set, ram_we, ram_clear, est_start, est_done, out_free;
    logic [SPREAD_W-1:0] est_spread;

    // Cell chain: the free-slot token ripples from cell 0 upward.
    assign take[0] = 1'b1;
    for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_cell
        lcs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .key      (in_reg.source_id),
            .take_in  (take[i]),
            .take_out (take[i+1]),
            .sel      (cell_sel[i]),
            .cmd      (cmd),
            .stat     (stat[i])
        );
        assign hit_vec[i]  = stat[i].hit;
        assign free_vec[i] = stat[i].first_free;
        assign cell_sel[i] = sel_vec_reg[i] & (state_reg == ST_WRITE) & is_rec;
    end

    lcs_ram #(.WIDTH(64), .DEPTH(RAM_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we | ram_clear),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    lcs_est u_est (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (est_start),
        .count   (sel_count),
        .done    (est_done),
        .spread  (est_spread)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign is_rec   = (in_reg.op == OP_RECORD);
    assign hit_any  = |hit_vec_reg;
    assign free_any = |free_vec_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == ADDR_W'(RAM_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_valid) state_next = MAP_POW2 ? ST_SEARCH : ST_MOD;
            ST_MOD:    if (bcnt_reg == 5'd31) state_next = ST_SEARCH;
            ST_SEARCH: state_next = ST_READ;
            ST_READ:   state_next = ST_WRITE;
            ST_WRITE:  state_next = (!is_rec && found_reg) ? ST_EST : ST_DONE;
            ST_EST:    if (est_done) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control and datapath outputs.
    always_comb begin
        s_ready = (state_reg == ST_IDLE);

        // Clearing pass over the bitmap RAM after reset.
        ram_clear = (state_reg == ST_CLEAR);
        clr_next  = ram_clear ? clr_reg + ADDR_W'(1) : clr_reg;

        // Remainder of the destination by the bitmap size: low bits for a power of two, else serial.
        rem_t     = {rem_reg, dsh_reg[SRC_W-1]};
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        bcnt_next = bcnt_reg;
        if (state_reg == ST_IDLE) begin
            rem_next  = MAP_POW2 ? s_data.dest_id[POS_W-1:0] : '0;
            dsh_next  = s_data.dest_id;
            bcnt_next = '0;
        end else if (state_reg == ST_MOD) begin
            if (rem_t >= (POS_W + 1)'(BITMAP_BITS)) begin
                rem_t = rem_t - (POS_W + 1)'(BITMAP_BITS);
            end
            rem_next  = rem_t[POS_W-1:0];
            dsh_next  = {dsh_reg[SRC_W-2:0], 1'b0};
            bcnt_next = bcnt_reg + 5'd1;
        end

        // Pick the matching cell, or the first free one for a record.
        if (hit_any) begin
            sel_vec = hit_vec_reg;
        end else if (is_rec) begin
            sel_vec = free_vec_reg;
        end else begin
            sel_vec = '0;
        end
        idx = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (sel_vec[i]) begin
                idx = idx | IDX_W'(i);
            end
        end

        word   = WORD_W'(rem_reg >> 6);
        bitpos = rem_reg[5:0];
        addr   = ADDR_W'(int'((state_reg == ST_READ) ? idx : idx_reg) * WORDS + int'(word));

        // Selected cell's count.
        sel_count = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            sel_count = sel_count | (stat[i].count & {CNT_W{sel_vec_reg[i]}});
        end

        // Free entries were zeroed by the clearing pass, so the word is used as read.
        old_word        = rdata;
        bit_mask        = '0;
        bit_mask[bitpos] = 1'b1;
        bit_was_set     = old_word[bitpos];
        ram_we          = (state_reg == ST_WRITE) && is_rec && found_reg;
        est_start       = (state_reg == ST_WRITE) && !is_rec && found_reg;
        waddr           = ram_clear ? clr_reg : addr;
        wdata           = ram_clear ? 64'd0 : (old_word | bit_mask);

        cmd.alloc     = alloc_reg;
        cmd.upd       = ~alloc_reg;
        cmd.source_id = in_reg.source_id;
        cmd.inc       = ~bit_was_set;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        bcnt_reg <= bcnt_next;
        if (state_reg == ST_IDLE && s_valid) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_SEARCH) begin
            hit_vec_reg  <= hit_vec;
            free_vec_reg <= free_vec;
        end
        if (state_reg == ST_READ) begin
            sel_vec_reg <= sel_vec;
            idx_reg     <= idx;
            alloc_reg   <= is_rec && !hit_any;
            found_reg   <= hit_any || (is_rec && free_any);
            full_reg    <= is_rec && !hit_any && !free_any;
            spread_reg  <= '0;
        end
        if (state_reg == ST_EST && est_done) begin
            spread_reg <= est_spread;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg.spread     <= spread_reg;
            m_data_reg.found      <= found_reg;
            m_data_reg.table_full <= full_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/lcs_chk.sv
// Port-level checker for the per-source spread counter, bound to the top level.
module lcs_chk
    import lcs_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input lcs_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input lcs_out_t m_data
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // A dropped record never reports its source as present.
    a_full_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_full |-> !m_data.found)
        else $error("table_full together with found");

    // Only a known source carries an estimate.
    a_spread_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.spread != '0) |-> m_data.found)
        else $error("nonzero spread without found");

    // One word at a time: acceptance closes the input until the block is done.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while busy");

endmodule

bind per_source_linear_counting_spread lcs_chk u_lcs_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
